FILE: rtl/core/trw_pkg.sv
// ----------------------------------------------------------------------------
// trw_pkg: shared types and constants for the ticketed reply window
// Command and status codes, field widths, parameter defaults and the
// controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package trw_pkg;

   localparam int DEF_CAPACITY      = 16;
   localparam int DEF_PAYLOAD_WIDTH = 32;

   localparam int CMD_W     = 2;
   localparam int TICKET_W  = 64;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 2;
   localparam int OCC_W     = 5;

   localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_REJECT  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOMATCH = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic latch;     // capture the request transaction
      logic exec;      // run store / clear / no-op on the latched command
      logic step;      // advance the scan pipeline by one slot
      logic hit;       // match found: capture payload, restart for compaction
      logic shift_wr;  // compaction: write back the slot read last cycle
      logic shift_end; // compaction finished: drop one entry
      logic load_rsp;  // move the finished result into the output register
   } trw_ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic hit;
      logic issue;
      logic pipe_valid;
      logic rsp_free;
   } trw_stat_type;

endpackage

FILE: rtl/core/trw_req_if.sv
// ----------------------------------------------------------------------------
// trw_req_if: request channel
// Valid/ready channel carrying command, ticket and payload.
// ----------------------------------------------------------------------------
interface trw_req_if;
   logic                           valid;
   logic                           ready;
   logic [trw_pkg::CMD_W-1:0]      command;
   logic [trw_pkg::TICKET_W-1:0]   ticket;
   logic [trw_pkg::PAYLOAD_W-1:0]  payload_in;

   modport source (output valid, output command, output ticket, output payload_in,
                   input ready);
   modport sink   (input valid, input command, input ticket, input payload_in,
                   output ready);
endinterface

FILE: rtl/core/trw_rsp_if.sv
// ----------------------------------------------------------------------------
// trw_rsp_if: response channel
// Valid/ready channel carrying status, taken payload and occupancy.
// ----------------------------------------------------------------------------
interface trw_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [trw_pkg::STATUS_W-1:0]   status;
   logic [trw_pkg::PAYLOAD_W-1:0]  payload_out;
   logic [trw_pkg::OCC_W-1:0]      occupancy;

   modport source (output valid, output status, output payload_out, output occupancy,
                   input ready);
   modport sink   (input valid, input status, input payload_out, input occupancy,
                   output ready);
endinterface

FILE: rtl/core/trw_controller.sv
// ----------------------------------------------------------------------------
// trw_controller: sequencing state machine
// Dispatches each command, runs the search and compaction scans and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module trw_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [trw_pkg::CMD_W-1:0]  req_command,
   output logic                       req_ready,
   input  trw_pkg::trw_stat_type      stat,
   output trw_pkg::trw_ctrl_type      ctrl
);
   import trw_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.latch = 1'b1;
               state_in   = (req_command == CMD_TAKE) ? S_SEARCH : S_EXEC;
            end
         end
         S_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = S_DONE;
         end
         S_SEARCH: begin
            if (stat.hit) begin
               ctrl.hit = 1'b1;
               state_in = S_SHIFT;
            end else begin
               ctrl.step = 1'b1;
               // nothing left to read and nothing in flight: no match
               if (!stat.issue && !stat.pipe_valid) begin
                  state_in = S_DONE;
               end
            end
         end
         S_SHIFT: begin
            ctrl.step     = 1'b1;
            ctrl.shift_wr = 1'b1;
            if (!stat.issue && !stat.pipe_valid) begin
               ctrl.shift_end = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               ctrl.load_rsp = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/trw_datapath.sv
// ----------------------------------------------------------------------------
// trw_datapath: slot memories, ring pointers and result registers
// Holds the ticket/payload ring, the scan pipeline used by search and
// compaction, and the output register of the response channel.
// ----------------------------------------------------------------------------
module trw_datapath #(
   parameter int CAPACITY      = trw_pkg::DEF_CAPACITY,
   parameter int PAYLOAD_WIDTH = trw_pkg::DEF_PAYLOAD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [trw_pkg::CMD_W-1:0]     req_command,
   input  logic [trw_pkg::TICKET_W-1:0]  req_ticket,
   input  logic [trw_pkg::PAYLOAD_W-1:0] req_payload_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [trw_pkg::STATUS_W-1:0]  rsp_status,
   output logic [trw_pkg::PAYLOAD_W-1:0] rsp_payload_out,
   output logic [trw_pkg::OCC_W-1:0]     rsp_occupancy,
   input  trw_pkg::trw_ctrl_type         ctrl,
   output trw_pkg::trw_stat_type         stat
);
   import trw_pkg::*;

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W   = COUNT_W + 1;
   localparam int STORE_W = (PAYLOAD_WIDTH < PAYLOAD_W) ? PAYLOAD_WIDTH : PAYLOAD_W;

   // (base + ofs) mod CAPACITY; both operands stay below twice the depth
   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [COUNT_W-1:0] ofs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(ofs);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [TICKET_W-1:0] slot_ticket_mem  [CAPACITY];
   logic [STORE_W-1:0]  slot_payload_mem [CAPACITY];

   logic [TICKET_W-1:0] rd_ticket_ff;
   logic [STORE_W-1:0]  rd_payload_ff;

   logic [CMD_W-1:0]     cmd_ff,         cmd_in;
   logic [TICKET_W-1:0]  ticket_ff,      ticket_in;
   logic [STORE_W-1:0]   payload_ff,     payload_in;
   logic [IDX_W-1:0]     oldest_ff,      oldest_in;
   logic [COUNT_W-1:0]   count_ff,       count_in;
   logic [COUNT_W-1:0]   off_ff,         off_in;
   logic                 pipe_valid_ff,  pipe_valid_in;
   logic [COUNT_W-1:0]   pipe_off_ff,    pipe_off_in;
   logic [STATUS_W-1:0]  work_status_ff, work_status_in;
   logic [PAYLOAD_W-1:0] work_result_ff, work_result_in;
   logic                 rsp_valid_ff,   rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff,  rsp_status_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic [OCC_W-1:0]     rsp_occ_ff,     rsp_occ_in;

   logic                 issue;
   logic                 hit;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 store_wr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [TICKET_W-1:0]  wr_ticket;
   logic [STORE_W-1:0]   wr_payload;
   logic [31:0]          occ_wide;

   assign issue   = (off_ff < count_ff);
   assign hit     = pipe_valid_ff && (rd_ticket_ff == ticket_ff);
   assign rd_en   = ctrl.step && issue;
   assign rd_addr = ring_pos(oldest_ff, off_ff);

   assign store_wr = ctrl.exec && (cmd_ff == CMD_STORE) && (ticket_ff != '0);
   assign wr_en    = store_wr || (ctrl.shift_wr && pipe_valid_ff);

   always_comb begin
      if (store_wr) begin
         wr_addr    = ring_pos(oldest_ff, count_ff);
         wr_ticket  = ticket_ff;
         wr_payload = payload_ff;
      end else begin
         // compaction: slot read last cycle moves down one place
         wr_addr    = ring_pos(oldest_ff, pipe_off_ff - COUNT_W'(1));
         wr_ticket  = rd_ticket_ff;
         wr_payload = rd_payload_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ticket_mem[wr_addr]  <= wr_ticket;
         slot_payload_mem[wr_addr] <= wr_payload;
      end
      if (rd_en) begin
         rd_ticket_ff  <= slot_ticket_mem[rd_addr];
         rd_payload_ff <= slot_payload_mem[rd_addr];
      end
   end

   assign occ_wide = 32'(count_ff);

   always_comb begin
      cmd_in         = cmd_ff;
      ticket_in      = ticket_ff;
      payload_in     = payload_ff;
      oldest_in      = oldest_ff;
      count_in       = count_ff;
      off_in         = off_ff;
      pipe_valid_in  = pipe_valid_ff;
      pipe_off_in    = pipe_off_ff;
      work_status_in = work_status_ff;
      work_result_in = work_result_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_occ_in     = rsp_occ_ff;

      if (ctrl.latch) begin
         cmd_in         = req_command;
         ticket_in      = req_ticket;
         payload_in     = req_payload_in[STORE_W-1:0];
         off_in         = '0;
         pipe_valid_in  = 1'b0;
         work_status_in = (req_command == CMD_TAKE) ? STAT_NOMATCH : STAT_OK;
         work_result_in = '0;
      end

      if (ctrl.exec) begin
         unique case (cmd_ff)
            CMD_STORE: begin
               if (ticket_ff == '0) begin
                  work_status_in = STAT_REJECT;
               end else if (count_ff < COUNT_W'(CAPACITY)) begin
                  count_in = count_ff + COUNT_W'(1);
               end else begin
                  // full: newest overwrote the oldest, window slides
                  oldest_in = ring_pos(oldest_ff, COUNT_W'(1));
               end
            end
            CMD_CLEAR: begin
               oldest_in = '0;
               count_in  = '0;
            end
            default: begin
            end
         endcase
      end

      if (ctrl.step) begin
         pipe_valid_in = issue;
         pipe_off_in   = off_ff;
         if (issue) begin
            off_in = off_ff + COUNT_W'(1);
         end
      end

      if (ctrl.hit) begin
         // compaction starts at the slot after the match
         off_in         = pipe_off_ff + COUNT_W'(1);
         pipe_valid_in  = 1'b0;
         work_status_in = STAT_OK;
         work_result_in = PAYLOAD_W'(rd_payload_ff);
      end

      if (ctrl.shift_end) begin
         count_in = count_ff - COUNT_W'(1);
      end

      if (ctrl.load_rsp) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = work_status_ff;
         rsp_payload_in = work_result_ff;
         rsp_occ_in     = occ_wide[OCC_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff     <= '0;
         count_ff      <= '0;
         pipe_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         pipe_valid_ff <= pipe_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      ticket_ff      <= ticket_in;
      payload_ff     <= payload_in;
      off_ff         <= off_in;
      pipe_off_ff    <= pipe_off_in;
      work_status_ff <= work_status_in;
      work_result_ff <= work_result_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   assign stat.hit        = hit;
   assign stat.issue      = issue;
   assign stat.pipe_valid = pipe_valid_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_ff;
   assign rsp_occupancy   = rsp_occ_ff;

endmodule

FILE: rtl/core/ticketed_reply_window.sv
// ----------------------------------------------------------------------------
// ticketed_reply_window: bounded window of ticketed replies
// Requests arrive on req_channel (command, ticket, payload_in); every
// request yields exactly one response on rsp_channel (status, payload_out,
// occupancy). Store appends, overwriting the oldest entry when full; take
// returns and removes the oldest entry with a matching ticket; clear empties.
// One request is in work at a time. Store, clear and the unused code pass
// through an execute step and then a done step, which loads the response.
// A take walks the ring through one registered memory read port, one slot
// per cycle, reading every entry on a miss. On a match the search stops
// there and the later entries are copied down one slot per cycle.
// The next request is accepted in the cycle after the response is loaded.
// The response sits in an output register; a new request is accepted while
// it waits, and a stalled receiver only holds the sequencer in its final
// step. Reset empties the window at once; slot memories are not cleared.
// ----------------------------------------------------------------------------
module ticketed_reply_window #(
   parameter int CAPACITY      = trw_pkg::DEF_CAPACITY,
   parameter int PAYLOAD_WIDTH = trw_pkg::DEF_PAYLOAD_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   trw_req_if.sink   req_channel,
   trw_rsp_if.source rsp_channel
);
   import trw_pkg::*;

   trw_ctrl_type ctrl;
   trw_stat_type stat;

   trw_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_channel.valid),
      .req_command (req_channel.command),
      .req_ready   (req_channel.ready),
      .stat        (stat),
      .ctrl        (ctrl)
   );

   trw_datapath #(
      .CAPACITY      (CAPACITY),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_channel.command),
      .req_ticket      (req_channel.ticket),
      .req_payload_in  (req_channel.payload_in),
      .rsp_valid       (rsp_channel.valid),
      .rsp_ready       (rsp_channel.ready),
      .rsp_status      (rsp_channel.status),
      .rsp_payload_out (rsp_channel.payload_out),
      .rsp_occupancy   (rsp_channel.occupancy),
      .ctrl            (ctrl),
      .stat            (stat)
   );

endmodule

FILE: tb/sv/ticketed_reply_window_test.sv
// ----------------------------------------------------------------------------
// ticketed_reply_window_test: self-checking testbench for the reply window
// Drives store, take, clear and unused-code transactions through the request
// channel, predicts each response with a ring model of the window and
// compares every response field. Random idling on both channels, a long
// receiver hold-off that backs up the request side, and sender pauses that
// let the window drain.
// ----------------------------------------------------------------------------
module ticketed_reply_window_test;
   timeunit 1ns;
   timeprecision 1ps;

   import trw_pkg::*;

   localparam int CAPACITY      = DEF_CAPACITY;
   localparam int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [PAYLOAD_W-1:0] PAYLOAD_KEEP =
      {PAYLOAD_W{1'b1}} >> (PAYLOAD_W - PAYLOAD_WIDTH);
   localparam int RANDOM_ITEMS  = 1450;
   localparam int QUIET_TAIL    = 120;

   typedef struct {
      logic                  pause;
      logic [CMD_W-1:0]      command;
      logic [TICKET_W-1:0]   ticket;
      logic [PAYLOAD_W-1:0]  payload;
   } request_type;

   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic [PAYLOAD_W-1:0]  payload;
      logic [OCC_W-1:0]      occupancy;
   } reply_type;

   logic clock;
   logic reset;

   trw_req_if req_bus ();
   trw_rsp_if rsp_bus ();

   ticketed_reply_window #(
      .CAPACITY      (CAPACITY),
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_bus),
      .rsp_channel (rsp_bus)
   );

   // window model
   logic [TICKET_W-1:0]  win_ticket [CAPACITY];
   logic [PAYLOAD_W-1:0] win_payload [CAPACITY];
   int unsigned          win_head;
   int unsigned          win_count;

   request_type          command_queue[$];
   reply_type            pending_replies[$];
   logic [TICKET_W-1:0]  recent_tickets[$];
   request_type          in_flight;
   int                   gap_left;
   int                   stall_left;
   int                   hold_left;
   bit                   hold_done;
   int                   accepted;
   int                   responses;
   int                   quiet_from;
   int                   mismatches;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic report(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic reply_type apply_to_window(input request_type rq);
      reply_type r;
      int unsigned pos;
      int unsigned dst;
      int unsigned src;
      bit found;
      r.status  = STAT_OK;
      r.payload = '0;
      found     = 1'b0;
      case (rq.command)
         CMD_STORE: begin
            if (rq.ticket == '0) begin
               r.status = STAT_REJECT;
            end else begin
               pos = (win_head + win_count) % CAPACITY;
               win_ticket[pos]  = rq.ticket;
               win_payload[pos] = rq.payload & PAYLOAD_KEEP;
               if (win_count < CAPACITY) win_count++;
               else win_head = (win_head + 1) % CAPACITY;
            end
         end
         CMD_TAKE: begin
            r.status = STAT_NOMATCH;
            for (int unsigned off = 0; off < win_count && !found; off++) begin
               pos = (win_head + off) % CAPACITY;
               if (win_ticket[pos] == rq.ticket) begin
                  found     = 1'b1;
                  r.payload = win_payload[pos];
                  r.status  = STAT_OK;
                  // close the gap, keeping arrival order
                  for (int unsigned mv = off; mv + 1 < win_count; mv++) begin
                     dst = (win_head + mv) % CAPACITY;
                     src = (win_head + mv + 1) % CAPACITY;
                     win_ticket[dst]  = win_ticket[src];
                     win_payload[dst] = win_payload[src];
                  end
               end
            end
            if (found) win_count--;
         end
         CMD_CLEAR: begin
            win_head  = 0;
            win_count = 0;
         end
         default: ;
      endcase
      r.occupancy = win_count[OCC_W-1:0];
      return r;
   endfunction

   task automatic add_request(input logic [CMD_W-1:0] cmd, input logic [TICKET_W-1:0] tk,
                              input logic [PAYLOAD_W-1:0] pl);
      request_type rq;
      rq.pause   = 1'b0;
      rq.command = cmd;
      rq.ticket  = tk;
      rq.payload = pl;
      command_queue.push_back(rq);
      if (cmd == CMD_STORE && tk != '0) begin
         recent_tickets.push_back(tk);
         if (recent_tickets.size() > 32) void'(recent_tickets.pop_front());
      end
   endtask

   task automatic add_pause();
      request_type rq;
      rq.pause   = 1'b1;
      rq.command = CMD_UNUSED;
      rq.ticket  = '0;
      rq.payload = '0;
      command_queue.push_back(rq);
   endtask

   function automatic logic [TICKET_W-1:0] pick_ticket();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 65) return TICKET_W'($urandom_range(1, 24));
      if (sel < 77) return {$urandom, $urandom};
      if (sel < 87 && recent_tickets.size() > 0)
         return recent_tickets[$urandom_range(0, recent_tickets.size() - 1)];
      if (sel < 93) return '0;
      if (sel < 97) return '1;
      return TICKET_W'(1) << $urandom_range(0, TICKET_W - 1);
   endfunction

   function automatic logic [TICKET_W-1:0] pick_take_ticket();
      if (recent_tickets.size() > 0 && $urandom_range(0, 99) < 60)
         return recent_tickets[$urandom_range(0, recent_tickets.size() - 1)];
      return pick_ticket();
   endfunction

   function automatic logic [PAYLOAD_W-1:0] pick_payload();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return $urandom;
   endfunction

   task automatic add_random_command();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) add_request(CMD_STORE, pick_ticket(), pick_payload());
      else if (sel < 88) add_request(CMD_TAKE, pick_take_ticket(), pick_payload());
      else if (sel < 94) add_request(CMD_CLEAR, pick_ticket(), pick_payload());
      else add_request(CMD_UNUSED, pick_ticket(), pick_payload());
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            pending_replies.push_back(apply_to_window(in_flight));
            accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_bus.valid <= 1'b0;
            end else if (command_queue.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (command_queue[0].pause) begin
               req_bus.valid <= 1'b0;
               if (pending_replies.size() == 0) void'(command_queue.pop_front());
            end else if (accepted < quiet_from && $urandom_range(0, 99) < 7) begin
               gap_left = $urandom_range(0, 6);
               req_bus.valid <= 1'b0;
            end else begin
               in_flight = command_queue.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.command    <= in_flight.command;
               req_bus.ticket     <= in_flight.ticket;
               req_bus.payload_in <= in_flight.payload;
            end
         end
      end
   end

   // response receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) responses++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && responses >= 250) begin
            hold_done = 1'b1;
            hold_left = 299;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (accepted < quiet_from && $urandom_range(0, 99) < 10) begin
            stall_left = $urandom_range(0, 6);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      reply_type exp_reply;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            report("response transaction with nothing expected");
         end else begin
            exp_reply = pending_replies.pop_front();
            if (rsp_bus.status !== exp_reply.status)
               report($sformatf("status %0d, expected %0d", rsp_bus.status, exp_reply.status));
            if (rsp_bus.payload_out !== exp_reply.payload)
               report($sformatf("payload_out %h, expected %h",
                                rsp_bus.payload_out, exp_reply.payload));
            if (rsp_bus.occupancy !== exp_reply.occupancy)
               report($sformatf("occupancy %0d, expected %0d",
                                rsp_bus.occupancy, exp_reply.occupancy));
         end
      end
   end

   initial begin
      int made;
      int n;
      int unsigned kind;
      bit paused_mid;
      logic [TICKET_W-1:0] dir_tickets [17];

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_STORE;
      req_bus.ticket     = '0;
      req_bus.payload_in = '0;
      rsp_bus.ready      = 1'b0;
      win_head   = 0;
      win_count  = 0;
      accepted   = 0;
      responses  = 0;
      mismatches = 0;
      hold_done  = 1'b0;
      quiet_from = 0;

      // directed: rejects, misses, unused code, wraparound, duplicates, clear
      add_request(CMD_STORE, '0, 32'h1234_5678);
      add_request(CMD_TAKE, 64'd5, '0);
      add_request(CMD_UNUSED, '1, '1);
      dir_tickets[0] = '1;
      dir_tickets[1] = 64'd2;
      dir_tickets[2] = 64'd3;
      dir_tickets[3] = 64'd3;
      for (int i = 4; i < 17; i++) dir_tickets[i] = 64'(i);
      for (int i = 0; i < 17; i++)
         add_request(CMD_STORE, dir_tickets[i],
                     i == 0 ? '1 : (i == 1 ? '0 : 32'h0101_0101 * i));
      add_request(CMD_TAKE, '0, '0);
      add_request(CMD_TAKE, 64'd3, '0);
      add_request(CMD_TAKE, 64'd16, '0);
      add_request(CMD_TAKE, 64'd2, '0);
      add_request(CMD_TAKE, '1, '0);
      add_request(CMD_CLEAR, '0, '0);
      add_pause();

      // random: fill runs, drain runs, mixed traffic, occasional clears
      made = 0;
      paused_mid = 1'b0;
      while (made < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 2) begin
            n = $urandom_range(4, 20);
            for (int i = 0; i < n; i++)
               add_request(CMD_STORE, $urandom_range(0, 9) == 0 ? '0 : pick_ticket(),
                           pick_payload());
         end else if (kind <= 5) begin
            n = $urandom_range(2, 12);
            for (int i = 0; i < n; i++) add_request(CMD_TAKE, pick_take_ticket(), pick_payload());
         end else if (kind <= 8) begin
            n = $urandom_range(5, 15);
            for (int i = 0; i < n; i++) add_random_command();
         end else begin
            n = 1;
            add_request($urandom_range(0, 1) ? CMD_CLEAR : CMD_UNUSED, pick_ticket(),
                        pick_payload());
         end
         made += n;
         if (!paused_mid && made > RANDOM_ITEMS / 2) begin
            paused_mid = 1'b1;
            add_pause();
         end
      end
      quiet_from = made + 26 - QUIET_TAIL;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (command_queue.size() != 0 || req_bus.valid || pending_replies.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      if (pending_replies.size() != 0)
         report($sformatf("%0d responses never arrived", pending_replies.size()));
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
